>>> hdl/hrlp_pkg.sv
// Shared types and constants of the request-line parser.
package hrlp_pkg;

  // Path store geometry: two banks of one message path each
  localparam int PATH_IDX_W      = 6;
  localparam int STORE_DEPTH     = 64;
  localparam int BANKS           = 2;
  localparam int ADDR_W          = 7;
  localparam int PATH_HARD_LIMIT = 63;
  localparam int MIN_BYTES       = 4;
  localparam int NUM_METHODS     = 5;

  // Method codes
  localparam logic [2:0] METH_GET    = 3'd0;
  localparam logic [2:0] METH_POST   = 3'd1;
  localparam logic [2:0] METH_PUT    = 3'd2;
  localparam logic [2:0] METH_DELETE = 3'd3;
  localparam logic [2:0] METH_PATCH  = 3'd4;

  // Path terminators
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [NUM_METHODS-1:0] ALL_CANDIDATES = '1;

  // Descriptor of one finished message, front to back
  typedef struct packed {
    logic                  accepted;
    logic [2:0]            method_code;
    logic [PATH_IDX_W-1:0] path_length;
    logic [8:0]            msg_size;
    logic                  bank;
  } desc_t;

  // Bank release, back to front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // Path store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // One result item
  typedef struct packed {
    logic                  accepted;
    logic [2:0]            method_code;
    logic [PATH_IDX_W-1:0] path_length;
    logic [8:0]            msg_size;
    logic [7:0]            path_char;
    logic                  path_char_valid;
    logic                  run_last;
  } out_item_t;

  // Token byte at a position; tokens are left-aligned in 56 bits
  function automatic logic [7:0] method_tok(input logic [2:0] m, input logic [2:0] pos);
    logic [55:0] s;
    logic [55:0] sh;
    unique case (m)
      METH_GET:    s = {8'h47, 8'h45, 8'h54, 8'h20, 24'h0};
      METH_POST:   s = {8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 16'h0};
      METH_PUT:    s = {8'h50, 8'h55, 8'h54, 8'h20, 24'h0};
      METH_DELETE: s = {8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20};
      METH_PATCH:  s = {8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h20, 8'h0};
      default:     s = '0;
    endcase
    sh = s << {pos, 3'b000};
    return sh[55:48];
  endfunction

  // Token length including the trailing space
  function automatic logic [2:0] method_len(input logic [2:0] m);
    logic [2:0] l;
    unique case (m)
      METH_GET:    l = 3'd4;
      METH_POST:   l = 3'd5;
      METH_PUT:    l = 3'd4;
      METH_DELETE: l = 3'd7;
      METH_PATCH:  l = 3'd6;
      default:     l = 3'd0;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/hrlp_if.sv
// Valid/ready channel interfaces for message bytes and result items.
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source(output valid, data_byte, first_byte, last_byte, input ready);
  modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface hrlp_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] method_code;
  logic [5:0] path_length;
  logic [8:0] msg_size;
  logic [7:0] path_char;
  logic       path_char_valid;
  logic       run_last;

  modport source(output valid, accepted, method_code, path_length, msg_size,
                 path_char, path_char_valid, run_last, input ready);
  modport sink(input valid, accepted, method_code, path_length, msg_size,
               path_char, path_char_valid, run_last, output ready);
endinterface

>>> hdl/hrlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hrlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/hrlp_front.sv
// Front end: byte counting, method match, path capture and message verdict.
module hrlp_front #(
  parameter int MAX_MESSAGE_BYTES = 256,
  parameter int PATH_MAX_BYTES    = 63
) (
  input  logic            clk,
  input  logic            rst_n,
  hrlp_in_if.sink         in_ch,
  input  logic            q_full,
  input  hrlp_pkg::rel_t  rel,
  output logic            q_push,
  output hrlp_pkg::desc_t q_desc,
  output hrlp_pkg::wr_t   ram_wr
);

  localparam int CW   = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int PLIM = (PATH_MAX_BYTES > hrlp_pkg::PATH_HARD_LIMIT) ?
                        hrlp_pkg::PATH_HARD_LIMIT : PATH_MAX_BYTES;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MESSAGE_BYTES);
  localparam logic [CW-1:0] MIN_CNT = CW'(hrlp_pkg::MIN_BYTES);
  localparam logic [hrlp_pkg::PATH_IDX_W-1:0] PLIM_V = hrlp_pkg::PATH_IDX_W'(PLIM);

  logic [CW-1:0]                       cnt_r, cnt_nxt, s_cnt;
  logic                                tl_r, tl_nxt, s_tl;
  logic [hrlp_pkg::NUM_METHODS-1:0]    cand_r, cand_nxt, s_cand;
  logic [2:0]                          meth_r, meth_nxt, s_meth;
  logic                                mv_r, mv_nxt, s_mv;
  logic [hrlp_pkg::PATH_IDX_W-1:0]     pcnt_r, pcnt_nxt, s_pcnt;
  logic                                pc_r, pc_nxt, s_pc;
  logic                                wr_bank_r;
  logic [hrlp_pkg::BANKS-1:0]          busy_r, busy_nxt;
  logic                                acc;
  logic                                term;
  logic                                reject;
  logic [2:0]                          mlen;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r[wr_bank_r] && !q_full;

  // Start of message clears the running state before the byte is taken
  always_comb begin
    s_cnt  = in_ch.first_byte ? '0 : cnt_r;
    s_tl   = in_ch.first_byte ? 1'b0 : tl_r;
    s_cand = in_ch.first_byte ? hrlp_pkg::ALL_CANDIDATES : cand_r;
    s_meth = in_ch.first_byte ? 3'd0 : meth_r;
    s_mv   = in_ch.first_byte ? 1'b0 : mv_r;
    s_pcnt = in_ch.first_byte ? '0 : pcnt_r;
    s_pc   = in_ch.first_byte ? 1'b0 : pc_r;
  end

  // Byte processing
  always_comb begin
    cnt_nxt  = s_cnt;
    tl_nxt   = s_tl;
    cand_nxt = s_cand;
    meth_nxt = s_meth;
    mv_nxt   = s_mv;
    pcnt_nxt = s_pcnt;
    pc_nxt   = s_pc;
    mlen     = 3'd0;
    ram_wr.en   = 1'b0;
    ram_wr.addr = {wr_bank_r, s_pcnt};
    ram_wr.data = in_ch.data_byte;
    term = (in_ch.data_byte == hrlp_pkg::CH_SPACE) ||
           (in_ch.data_byte == hrlp_pkg::CH_QMARK) ||
           (in_ch.data_byte == hrlp_pkg::CH_CR);
    if (s_cnt >= MAX_CNT) begin
      tl_nxt = 1'b1;
    end else begin
      cnt_nxt = s_cnt + CW'(1);
      if (s_mv) begin
        // path capture
        if (!s_pc) begin
          if (term || s_pcnt >= PLIM_V) begin
            pc_nxt = 1'b1;
          end else begin
            ram_wr.en = acc;
            pcnt_nxt  = s_pcnt + hrlp_pkg::PATH_IDX_W'(1);
          end
        end
      end else begin
        // method token match over the live candidates
        for (int i = 0; i < hrlp_pkg::NUM_METHODS; i++) begin
          mlen = hrlp_pkg::method_len(3'(i));
          if (s_cand[i]) begin
            if (s_cnt >= CW'(mlen) ||
                in_ch.data_byte != hrlp_pkg::method_tok(3'(i), s_cnt[2:0])) begin
              cand_nxt[i] = 1'b0;
            end else if (s_cnt + CW'(1) == CW'(mlen)) begin
              meth_nxt = 3'(i);
              mv_nxt   = 1'b1;
            end
          end
        end
      end
    end
  end

  // Verdict at the last byte
  always_comb begin
    reject = tl_nxt || (cnt_nxt < MIN_CNT) || !mv_nxt;
    q_push = acc && in_ch.last_byte;
    q_desc.accepted    = !reject;
    q_desc.method_code = reject ? 3'd0 : meth_nxt;
    q_desc.path_length = reject ? '0 : pcnt_nxt;
    q_desc.msg_size    = reject ? 9'd0 : 9'(cnt_nxt);
    q_desc.bank        = wr_bank_r;
  end

  // Bank ownership: set when a message is handed over, cleared on release
  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push) begin
      busy_nxt[wr_bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      tl_r      <= 1'b0;
      cand_r    <= hrlp_pkg::ALL_CANDIDATES;
      meth_r    <= 3'd0;
      mv_r      <= 1'b0;
      pcnt_r    <= '0;
      pc_r      <= 1'b0;
      wr_bank_r <= 1'b0;
      busy_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (acc) begin
        if (in_ch.last_byte) begin
          cnt_r     <= '0;
          tl_r      <= 1'b0;
          cand_r    <= hrlp_pkg::ALL_CANDIDATES;
          meth_r    <= 3'd0;
          mv_r      <= 1'b0;
          pcnt_r    <= '0;
          pc_r      <= 1'b0;
          wr_bank_r <= !wr_bank_r;
        end else begin
          cnt_r  <= cnt_nxt;
          tl_r   <= tl_nxt;
          cand_r <= cand_nxt;
          meth_r <= meth_nxt;
          mv_r   <= mv_nxt;
          pcnt_r <= pcnt_nxt;
          pc_r   <= pc_nxt;
        end
      end
    end
  end

endmodule

>>> hdl/hrlp_queue.sv
// Two-entry descriptor queue between front and back.
module hrlp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hrlp_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output hrlp_pkg::desc_t head
);

  hrlp_pkg::desc_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hdl/hrlp_back.sv
// Back end: reads a message's path out of the store and emits the result run.
module hrlp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  hrlp_pkg::desc_t               q_head,
  output logic                          q_pop,
  output hrlp_pkg::rel_t                rel,
  output logic                          ram_re,
  output logic [hrlp_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [7:0]                    ram_rdata,
  hrlp_out_if.source                    out_ch
);

  logic [hrlp_pkg::PATH_IDX_W-1:0] k_r;
  logic [hrlp_pkg::PATH_IDX_W-1:0] n_eff;
  logic                            s1_valid_r;
  hrlp_pkg::out_item_t             s1_item_r;
  hrlp_pkg::out_item_t             push_item;
  hrlp_pkg::out_item_t             ofifo_r [2];
  hrlp_pkg::out_item_t             head_item;
  logic                            owp_r, orp_r;
  logic [1:0]                      ocnt_r;
  logic [1:0]                      occ;
  logic                            pop;
  logic                            room;
  logic                            issue;
  logic                            issue_last;

  // Issue one store read per path byte, or one bare item for an empty path, while the output side has room
  always_comb begin
    n_eff      = (q_head.path_length == '0) ? hrlp_pkg::PATH_IDX_W'(1) : q_head.path_length;
    pop        = out_ch.valid && out_ch.ready;
    occ        = ocnt_r + {1'b0, s1_valid_r};
    room       = (occ - {1'b0, pop}) < 2'd2;
    issue      = q_valid && room;
    issue_last = (k_r + hrlp_pkg::PATH_IDX_W'(1)) == n_eff;
    q_pop      = issue && issue_last;
    rel.valid  = q_pop;
    rel.bank   = q_head.bank;
    ram_re     = issue && (q_head.path_length != '0);
    ram_raddr  = {q_head.bank, k_r};
  end

  // Read data joins the item in the cycle after issue
  always_comb begin
    push_item = s1_item_r;
    push_item.path_char = s1_item_r.path_char_valid ? ram_rdata : 8'd0;
  end

  assign head_item              = ofifo_r[orp_r];
  assign out_ch.valid           = (ocnt_r != 2'd0);
  assign out_ch.accepted        = head_item.accepted;
  assign out_ch.method_code     = head_item.method_code;
  assign out_ch.path_length     = head_item.path_length;
  assign out_ch.msg_size        = head_item.msg_size;
  assign out_ch.path_char       = head_item.path_char;
  assign out_ch.path_char_valid = head_item.path_char_valid;
  assign out_ch.run_last        = head_item.run_last;

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r.accepted        <= q_head.accepted;
      s1_item_r.method_code     <= q_head.method_code;
      s1_item_r.path_length     <= q_head.path_length;
      s1_item_r.msg_size        <= q_head.msg_size;
      s1_item_r.path_char       <= 8'd0;
      s1_item_r.path_char_valid <= (q_head.path_length != '0);
      s1_item_r.run_last        <= issue_last;
    end
    if (s1_valid_r) begin
      ofifo_r[owp_r] <= push_item;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      s1_valid_r <= 1'b0;
      owp_r      <= 1'b0;
      orp_r      <= 1'b0;
      ocnt_r     <= 2'd0;
    end else begin
      s1_valid_r <= issue;
      if (issue) begin
        k_r <= issue_last ? '0 : k_r + hrlp_pkg::PATH_IDX_W'(1);
      end
      if (s1_valid_r) begin
        owp_r <= !owp_r;
      end
      if (pop) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= ocnt_r + {1'b0, s1_valid_r} - {1'b0, pop};
    end
  end

endmodule

>>> hdl/http_request_line_parser_unit.sv
// Top level of the request-line parser: front end, descriptor queue, path store, back end.
//
// in_ch carries one message byte per item with first_byte/last_byte marks.
// out_ch carries the results of a message after its last byte: one item per
// path byte (up to 63), or one item when the path is empty or the message is
// rejected. run_last marks the final item of a message.
// Throughput: one input byte per cycle while in_ch.ready is high.
// Results leave at one per cycle while out_ch.ready is high.
// The first result of a message passes through the descriptor queue, the store read
// and the output register before out_ch offers it.
// The path store holds two banks, one per message in flight; in_ch.ready drops
// while the bank the next message would write is still held by a queued or draining
// message, so a message may start only while at most one earlier message is being drained.
// A stall on out_ch fills the two-entry output buffer, then stops store reads,
// then, once both banks are held, stops input.
// Reset (rst_n low, synchronous) empties the queue and buffers and clears the
// message state; the path store itself is not cleared and needs no sweep.
module http_request_line_parser_unit #(
  parameter int MAX_MESSAGE_BYTES = 256,
  parameter int PATH_MAX_BYTES    = 63
) (
  input logic        clk,
  input logic        rst_n,
  hrlp_in_if.sink    in_ch,
  hrlp_out_if.source out_ch
);

  logic                          q_push, q_full, q_pop, q_valid;
  hrlp_pkg::desc_t               q_desc, q_head;
  hrlp_pkg::rel_t                rel;
  hrlp_pkg::wr_t                 ram_wr;
  logic                          ram_re;
  logic [hrlp_pkg::ADDR_W-1:0]   ram_raddr;
  logic [7:0]                    ram_rdata;

  hrlp_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
    .PATH_MAX_BYTES   (PATH_MAX_BYTES)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_full(q_full),
    .rel   (rel),
    .q_push(q_push),
    .q_desc(q_desc),
    .ram_wr(ram_wr)
  );

  hrlp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(q_desc),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  hrlp_ram #(
    .WIDTH(8),
    .DEPTH(hrlp_pkg::BANKS * hrlp_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_wr.en),
    .waddr(ram_wr.addr),
    .wdata(ram_wr.data),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hrlp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .rel      (rel),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_ch   (out_ch)
  );

  // A message is never handed over into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("descriptor pushed into full queue");

  // A bank is released only while its descriptor sits at the queue head
  a_rel_head: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |-> (q_valid && rel.bank == q_head.bank))
    else $error("bank released without a queued message");

  // An item without a path byte is always the only item of its message
  a_nochar_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.path_char_valid |-> out_ch.run_last)
    else $error("empty-path item not marked last");

  // Rejected messages carry no size, path or method
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.accepted |->
      (out_ch.path_length == 6'd0 && out_ch.msg_size == 9'd0 &&
       out_ch.method_code == 3'd0 && !out_ch.path_char_valid))
    else $error("rejected item has nonzero fields");

endmodule

>>> bench/http_request_line_parser_unit_tb.sv
// Testbench for the request-line parser: directed and random messages, scoreboard check.
`timescale 1ns / 1ps

module http_request_line_parser_unit_tb;

  localparam int MAX_BYTES   = 256;
  localparam int PATH_MAX    = 63;
  localparam int PATH_LIM    = (PATH_MAX > hrlp_pkg::PATH_HARD_LIMIT) ?
                               hrlp_pkg::PATH_HARD_LIMIT : PATH_MAX;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int END_PAUSE   = 24;

  typedef logic [7:0] octet_queue_t[$];

  logic clk;
  logic rst_n;

  hrlp_in_if  in_ch();
  hrlp_out_if out_ch();

  http_request_line_parser_unit #(
    .MAX_MESSAGE_BYTES(MAX_BYTES),
    .PATH_MAX_BYTES(PATH_MAX)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Parser state mirror
  int unsigned msg_bytes;
  bit          msg_overflow;
  logic [4:0]  verb_live;
  logic [2:0]  verb_code;
  bit          verb_seen;
  logic [7:0]  path_buf[64];
  int unsigned path_fill;
  bit          path_done;

  hrlp_pkg::out_item_t pending_results[$];
  int          fault_count = 0;
  int          quiet_cycles = 0;
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Method token text, trailing space included
  function automatic string verb_text(input logic [2:0] code);
    string s;
    case (code)
      hrlp_pkg::METH_GET:    s = "GET ";
      hrlp_pkg::METH_POST:   s = "POST ";
      hrlp_pkg::METH_PUT:    s = "PUT ";
      hrlp_pkg::METH_DELETE: s = "DELETE ";
      hrlp_pkg::METH_PATCH:  s = "PATCH ";
      default:               s = "";
    endcase
    return s;
  endfunction

  function automatic void clear_msg();
    msg_bytes    = 0;
    msg_overflow = 1'b0;
    verb_live    = '1;
    verb_code    = hrlp_pkg::METH_GET;
    verb_seen    = 1'b0;
    path_fill    = 0;
    path_done    = 1'b0;
  endfunction

  // Advance the mirror by one accepted byte; queue the results it causes
  function automatic void parse_byte(input logic [7:0] d, input bit f, input bit l);
    int unsigned         pos;
    string               v;
    hrlp_pkg::out_item_t r;
    if (f) clear_msg();
    pos = msg_bytes;
    if (msg_bytes >= MAX_BYTES) begin
      msg_overflow = 1'b1;
    end else begin
      msg_bytes++;
      if (verb_seen) begin
        if (!path_done) begin
          if (d == hrlp_pkg::CH_SPACE || d == hrlp_pkg::CH_QMARK ||
              d == hrlp_pkg::CH_CR || path_fill >= PATH_LIM) begin
            path_done = 1'b1;
          end else begin
            path_buf[path_fill] = d;
            path_fill++;
          end
        end
      end else begin
        for (int i = 0; i < hrlp_pkg::NUM_METHODS; i++) begin
          if (verb_live[i]) begin
            v = verb_text(3'(i));
            if (pos >= v.len() || d != v[pos]) begin
              verb_live[i] = 1'b0;
            end else if (pos + 1 == v.len()) begin
              verb_code = 3'(i);
              verb_seen = 1'b1;
            end
          end
        end
      end
    end
    if (!l) return;
    r = '0;
    r.run_last = 1'b1;
    if (msg_overflow || msg_bytes < hrlp_pkg::MIN_BYTES || !verb_seen) begin
      pending_results.push_back(r);
    end else if (path_fill == 0) begin
      r.accepted    = 1'b1;
      r.method_code = verb_code;
      r.msg_size    = 9'(msg_bytes);
      pending_results.push_back(r);
    end else begin
      for (int k = 0; k < path_fill; k++) begin
        r.accepted        = 1'b1;
        r.method_code     = verb_code;
        r.path_length     = 6'(path_fill);
        r.msg_size        = 9'(msg_bytes);
        r.path_char       = path_buf[k];
        r.path_char_valid = 1'b1;
        r.run_last        = (k + 1 == path_fill);
        pending_results.push_back(r);
      end
    end
    clear_msg();
  endfunction

  function automatic octet_queue_t text(input string s);
    octet_queue_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Path bytes: anything but a terminator
  function automatic octet_queue_t path_bytes(input int n);
    octet_queue_t q;
    logic [7:0]   b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255));
      while (b == hrlp_pkg::CH_SPACE || b == hrlp_pkg::CH_QMARK || b == hrlp_pkg::CH_CR);
      q.push_back(b);
    end
    return q;
  endfunction

  function automatic octet_queue_t noise_bytes(input int n);
    octet_queue_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Offer one item and wait for the handshake; valid stays up afterwards
  task automatic push_byte(input logic [7:0] d, input bit f, input bit l);
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.first_byte <= f;
    in_ch.last_byte  <= l;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    parse_byte(d, f, l);
  endtask

  task automatic send_msg(input octet_queue_t m, input bit mark_first,
                          input bit mark_last = 1'b1);
    for (int i = 0; i < m.size(); i++)
      push_byte(m[i], mark_first && i == 0, mark_last && i == m.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Every method with a short path, then the bare minimum request
  task automatic test_methods();
    for (int i = 0; i < hrlp_pkg::NUM_METHODS; i++)
      send_msg({text(verb_text(3'(i))), text("/"), path_bytes(1), text(" ")}, 1'b1);
    send_msg(text(verb_text(hrlp_pkg::METH_GET)), 1'b1);
    wait_drained();
  endtask

  // Messages that must be turned away, and unmarked or restarted messages
  task automatic test_rejects();
    send_msg(text("G"), 1'b1);
    send_msg(text("GET"), 1'b1);
    send_msg(text("GETX"), 1'b1);
    send_msg(text("get /a "), 1'b1);
    send_msg(text("POSX /a"), 1'b1);
    send_msg(text("PATCH /z"), 1'b0);
    // unfinished message cut short by a new first byte
    send_msg(text("DELE"), 1'b1, 1'b0);
    send_msg(text("PUT /q?x"), 1'b1);
    // last byte alone right after a finished message
    send_msg(noise_bytes(1), 1'b0);
    wait_drained();
  endtask

  // Terminators, empty path, extreme byte values, path limit
  task automatic test_path_edges();
    send_msg(text("PUT /p\r\n"), 1'b1);
    send_msg(text("DELETE  x"), 1'b1);
    send_msg({text(verb_text(hrlp_pkg::METH_GET)), 8'h00, 8'hFF, 8'h80, 8'h7F}, 1'b1);
    send_msg({text(verb_text(hrlp_pkg::METH_PATCH)), path_bytes(PATH_MAX), text("Z")}, 1'b1);
    wait_drained();
  endtask

  // Mostly well-formed requests with random content, some broken, some noise
  task automatic test_random_traffic(input int budget);
    octet_queue_t m;
    int           sent;
    int           pick;
    int           plen;
    int           idx;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
      m = {text(verb_text(3'($urandom_range(0, hrlp_pkg::NUM_METHODS - 1)))),
           path_bytes(plen)};
      case ($urandom_range(0, 3))
        1: m.push_back(hrlp_pkg::CH_SPACE);
        2: m.push_back(hrlp_pkg::CH_QMARK);
        3: m.push_back(hrlp_pkg::CH_CR);
        default: ;
      endcase
      m = {m, noise_bytes($urandom_range(0, 6))};
      if (pick >= 70 && pick < 78) begin
        // flip one bit in the method token
        idx = $urandom_range(0, 3);
        m[idx] = m[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick >= 78 && pick < 85) begin
        m = m[0 : $urandom_range(0, 5)];
      end else if (pick >= 85) begin
        m = noise_bytes($urandom_range(1, 8));
      end
      if ($urandom_range(0, 15) == 0) begin
        send_msg(text("PAT"), 1'b1, 1'b0);
        sent += 3;
      end
      send_msg(m, $urandom_range(0, 7) != 0);
      sent += m.size();
    end
  endtask

  // Receiver holds off while requests keep coming, so input stalls
  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++)
      send_msg({text(verb_text(hrlp_pkg::METH_GET)), text("/"), path_bytes(8), text(" ")},
               1'b1);
    wait_drained();
  endtask

  // Result sink: random stall bursts, long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    hrlp_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation: path_char %0d run_last %0d",
               out_ch.path_char, out_ch.run_last);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, out_ch.accepted);
        check_field("method_code", want.method_code, out_ch.method_code);
        check_field("path_length", want.path_length, out_ch.path_length);
        check_field("msg_size", want.msg_size, out_ch.msg_size);
        check_field("path_char", want.path_char, out_ch.path_char);
        check_field("path_char_valid", want.path_char_valid, out_ch.path_char_valid);
        check_field("run_last", want.run_last, out_ch.run_last);
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("http_request_line_parser_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    clear_msg();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_methods();
    test_rejects();
    test_path_edges();
    test_random_traffic(15);
    test_backpressure();
    // closing stretch at full rate on both sides
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_random_traffic(15);
    wait_drained();
    repeat (END_PAUSE) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0)
      $display("http_request_line_parser_unit_tb: PASS");
    else
      $display("http_request_line_parser_unit_tb: FAIL");
    $finish;
  end

endmodule
